FILE: rtl/pcb_pkg.sv
// Shared constants and types of the pretrigger capture buffer.
package pcb_pkg;

  // Number of entries in the capture ring (2 .. 64).
  localparam int DEPTH = 64;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 64;

  // Beat kinds carried in tuser.
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_REARM   = 2'd2;

  typedef enum logic {
    ST_RUN,
    ST_REPLAY
  } state_t;

  // Request from the control logic to the sample store.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } store_req_t;

  // Ring index after idx, wrapping at the last entry.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
    logic [PTR_W-1:0] res;
    if (idx == PTR_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

FILE: rtl/pcb_store.sv
// Sample store: single write port, single read port, registered read data.
module pcb_store (
  input  logic                       clk,
  input  pcb_pkg::store_req_t        req,
  output logic [pcb_pkg::WORD_W-1:0] rdata
);

  logic [pcb_pkg::WORD_W-1:0] mem [pcb_pkg::DEPTH];
  logic [pcb_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pretrigger_capture_buffer_top.sv
// Pretrigger capture buffer: ring capture before a trigger, replay, then passthrough.
// Flow: a passthrough beat enters the output register in the cycle after it is accepted;
//   replay words move from the store's read register to it, one per cycle while consumed.
// Throughput: one input beat per cycle while the output register has room; no input is
//   taken during a replay, which is paced by the single read port of the sample store.
// Reset: synchronous, active low; clears state, pointers, count, trigger flag, replay bookkeeping and handshakes.
module pretrigger_capture_buffer_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_time[23:0], sample_altitude[47:24], sample_accel[63:48]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_time[23:0], out_altitude[47:24], out_accel[63:48]
  output logic        out_tlast   // last_of_run
);

  localparam int PTR_W = pcb_pkg::PTR_W;
  localparam int CNT_W = pcb_pkg::CNT_W;

  // Control state.
  pcb_pkg::state_t  state_r, state_nxt;
  logic             triggered_r, triggered_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] ridx_r, ridx_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             last_pend_r, last_pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Output payload register.
  logic [63:0]      out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 rd_issue;
  logic                 rd_deliver;
  logic                 ring_full;
  logic                 do_trigger;
  logic                 do_pass;
  logic [63:0]          rdata;
  pcb_pkg::store_req_t  store_req;

  assign out_free   = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign ring_full  = (count_r == CNT_W'(pcb_pkg::DEPTH));

  // A passthrough beat is any sample or trigger once the trigger flag is set.
  assign do_pass    = in_fire && triggered_r &&
                      (in_tuser == pcb_pkg::OP_SAMPLE || in_tuser == pcb_pkg::OP_TRIGGER);
  // The first trigger starts a replay, unless the ring holds nothing.
  assign do_trigger = in_fire && !triggered_r && (in_tuser == pcb_pkg::OP_TRIGGER);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcb_pkg::ST_RUN: begin
        if (do_trigger && (count_r != '0)) begin
          state_nxt = pcb_pkg::ST_REPLAY;
        end
      end
      pcb_pkg::ST_REPLAY: begin
        if (rd_deliver && last_pend_r) begin
          state_nxt = pcb_pkg::ST_RUN;
        end
      end
      default: state_nxt = pcb_pkg::ST_RUN;
    endcase
  end

  // State machine outputs. Input is taken only outside a replay and only when the
  // output register has room. During a replay, the next read is issued in the same
  // cycle as the pending word moves into the output register.
  always_comb begin
    in_tready  = 1'b0;
    rd_deliver = 1'b0;
    rd_issue   = 1'b0;
    case (state_r)
      pcb_pkg::ST_RUN: begin
        in_tready = out_free;
      end
      pcb_pkg::ST_REPLAY: begin
        rd_deliver = rd_pend_r && out_free;
        rd_issue   = (remain_r != '0) && (!rd_pend_r || rd_deliver);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Store access: samples are written before the trigger, the ring is read during replay.
  always_comb begin
    store_req.we    = in_fire && !triggered_r && (in_tuser == pcb_pkg::OP_SAMPLE);
    store_req.waddr = wp_r;
    store_req.wdata = in_tdata;
    store_req.re    = rd_issue;
    store_req.raddr = ridx_r;
  end

  pcb_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  // Pointer, count, trigger flag and replay bookkeeping.
  always_comb begin
    triggered_nxt = triggered_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    ridx_nxt      = ridx_r;
    remain_nxt    = remain_r;
    rd_pend_nxt   = rd_pend_r;
    last_pend_nxt = last_pend_r;

    if (in_fire) begin
      case (in_tuser)
        pcb_pkg::OP_REARM: begin
          triggered_nxt = 1'b0;
          wp_nxt        = '0;
          count_nxt     = '0;
        end
        pcb_pkg::OP_SAMPLE: begin
          if (!triggered_r) begin
            wp_nxt = pcb_pkg::ring_next(wp_r);
            if (!ring_full) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        pcb_pkg::OP_TRIGGER: begin
          if (!triggered_r) begin
            triggered_nxt = 1'b1;
            // Oldest entry sits at the write pointer once the ring has wrapped.
            ridx_nxt      = ring_full ? wp_r : '0;
            remain_nxt    = count_r;
          end
        end
        default: begin
          triggered_nxt = triggered_r;
        end
      endcase
    end

    if (rd_deliver) begin
      rd_pend_nxt = 1'b0;
    end
    if (rd_issue) begin
      rd_pend_nxt   = 1'b1;
      last_pend_nxt = (remain_r == CNT_W'(1));
      remain_nxt    = remain_r - CNT_W'(1);
      ridx_nxt      = pcb_pkg::ring_next(ridx_r);
    end
  end

  // Output register: a replay word, a passthrough beat, or drained by the consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (rd_deliver) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rdata;
      out_last_nxt  = last_pend_r;
    end else if (do_pass) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = in_tdata;
      out_last_nxt  = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcb_pkg::ST_RUN;
      triggered_r <= 1'b0;
      wp_r        <= '0;
      count_r     <= '0;
      ridx_r      <= '0;
      remain_r    <= '0;
      rd_pend_r   <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      triggered_r <= triggered_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      ridx_r      <= ridx_nxt;
      remain_r    <= remain_nxt;
      rd_pend_r   <= rd_pend_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/pcb_checker.sv
// Port-level checks of the pretrigger capture buffer, bound to the top level.
module pcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // No input is taken while a result waits with nowhere to go.
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output register blocked");

  // A rearm taken while the result channel is empty produces no result.
  a_rearm_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == pcb_pkg::OP_REARM) && !out_tvalid
    |=> !out_tvalid)
    else $error("rearm produced a result beat");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind pretrigger_capture_buffer_top pcb_checker u_pcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
